// ===== rtl/linear_fade_gain_top_defines.svh =====
// Assertion macros shared by the linear fade gain RTL.
`ifndef LINEAR_FADE_GAIN_TOP_DEFINES_SVH
`define LINEAR_FADE_GAIN_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LFG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LFG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/lfg_pkg.sv =====
// Shared types, constants and register indexes of the linear fade gain block.
`default_nettype none

package lfg_pkg;

   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_FRAME_BITS   = 24;
   localparam int DEF_MAX_CHANNELS = 8;

   localparam int CSR_INDEX_BITS     = 2;
   localparam int CHANNEL_COUNT_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_DIRECTION = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOTAL_FRAMES   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } lfg_state_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } lfg_unit_status_type;

endpackage

`default_nettype wire

// ===== rtl/lfg_channels.sv =====
// Valid/ready channel interfaces: sample input, sample output, register writes.
`default_nettype none

interface lfg_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface lfg_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface lfg_csr_if #(parameter int INDEX_BITS = 2, parameter int DATA_BITS = 24);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfg_mul.sv =====
// Bit-serial shift-add multiplier: one multiplicand bit per cycle, MSB first.
`default_nettype none

module lfg_mul
   import lfg_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [SAMPLE_BITS-1:0]            mag,
   input  wire logic [FRAME_BITS-1:0]             num,
   output logic      [SAMPLE_BITS+FRAME_BITS-1:0] product,
   output lfg_unit_status_type                    status
);

   localparam int PROD_W = SAMPLE_BITS + FRAME_BITS;
   localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] mag_sh_ff, mag_sh_in;
   logic [FRAME_BITS-1:0]  num_ff, num_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [PROD_W-1:0]      addend;

   always_comb begin
      addend    = mag_sh_ff[SAMPLE_BITS-1] ? PROD_W'(num_ff) : '0;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mag_sh_in = mag_sh_ff;
      num_in    = num_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_W'(SAMPLE_BITS);
         mag_sh_in = mag;
         num_in    = num;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = (acc_ff << 1) + addend;
         mag_sh_in = mag_sh_ff << 1;
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_sh_ff <= mag_sh_in;
      num_ff    <= num_in;
      acc_ff    <= acc_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/lfg_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient known to fit SAMPLE_BITS.
`default_nettype none

module lfg_div
   import lfg_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [SAMPLE_BITS+FRAME_BITS-1:0] dividend,
   input  wire logic [FRAME_BITS-1:0]             divisor,
   output logic      [SAMPLE_BITS-1:0]            quotient,
   output lfg_unit_status_type                    status
);

   localparam int PROD_W = SAMPLE_BITS + FRAME_BITS;
   localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [FRAME_BITS-1:0]  dvs_ff, dvs_in;
   logic [FRAME_BITS:0]    trial;
   logic                   fits;

   // The upper part of the dividend is already below the divisor, so only
   // SAMPLE_BITS steps are needed. Quotient bits replace the low bits.
   always_comb begin
      trial   = {rem_ff, low_ff[SAMPLE_BITS-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SAMPLE_BITS);
         rem_in  = dividend[PROD_W-1:SAMPLE_BITS];
         low_in  = dividend[SAMPLE_BITS-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? FRAME_BITS'(trial - {1'b0, dvs_ff}) : trial[FRAME_BITS-1:0];
         low_in = {low_ff[SAMPLE_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = low_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/linear_fade_gain_top.sv =====
// Top level of the linear fade gain: counters, gain select, serial datapath, output word.
`default_nettype none
`include "linear_fade_gain_top_defines.svh"

// Linear fade in / fade out over interleaved signed audio samples.
// req_ch carries one sample word per handshake; rsp_ch returns exactly one
// scaled word per accepted input, in order. Frame k of a run of N frames is
// scaled by k/N (fade in) or (N-k)/N (fade out), truncated toward zero;
// k saturates at N.
// csr_ch writes registers: 0 fade direction, 1 total frames, 2 channel count.
// Any write to those three clears the frame and channel counters; writes to
// other indexes are taken and ignored. csr_ch is always ready.
// Timing: an input word is accepted in IDLE; the shift-add multiplier then
// runs, its done strobe starts the restoring divider, and the divider's done
// moves the state to DONE, which loads the output register once it is free
// and raises rsp_ch.valid. A new word is accepted only after the state is
// back in IDLE, so each word goes through the bit-serial multiply and divide
// before the next; the two share nothing and run back to back.
// The output register lets the next word be accepted while a result waits;
// if rsp_ch stalls, the finished quotient is held in DONE and req_ch.ready
// stays low until the output register frees.
// Reset (synchronous, active high) sets fade in, N = 1, one channel, and
// clears both counters and all valid flags.

module linear_fade_gain_top
   import lfg_pkg::*;
#(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int FRAME_BITS   = DEF_FRAME_BITS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input wire logic  clock,
   input wire logic  reset,
   lfg_req_if.sink   req_ch,
   lfg_rsp_if.source rsp_ch,
   lfg_csr_if.sink   csr_ch
);

   localparam int PROD_W = SAMPLE_BITS + FRAME_BITS;
   localparam int CH_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W   = CHANNEL_COUNT_BITS + 1;
   localparam logic [CMP_W-1:0] MAX_CH = CMP_W'(MAX_CHANNELS);

   // configuration registers
   logic                          fade_dir_ff, fade_dir_in;
   logic [FRAME_BITS-1:0]         total_frames_ff, total_frames_in;
   logic [CHANNEL_COUNT_BITS-1:0] channel_count_ff, channel_count_in;

   // position counters
   logic [FRAME_BITS-1:0] frame_index_ff, frame_index_in;
   logic [CH_BITS-1:0]    channel_index_ff, channel_index_in;

   // control
   lfg_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          neg_ff, neg_in;
   logic [FRAME_BITS-1:0]  n_ff, n_in;
   logic [SAMPLE_BITS-1:0] sample_out_ff, sample_out_in;

   logic req_accept, csr_write, cfg_hit, out_load, mul_start, div_start;
   logic frame_last;
   logic [FRAME_BITS-1:0]  n_eff, k_eff, num;
   logic [CMP_W-1:0]       ch_eff;
   logic [SAMPLE_BITS-1:0] raw, mag;
   logic                   raw_neg;
   logic [PROD_W-1:0]      product;
   logic [SAMPLE_BITS-1:0] quotient;
   lfg_unit_status_type    mul_st, div_st;

   // ---------------- gain and magnitude at accept ----------------
   always_comb begin
      n_eff = (total_frames_ff == '0) ? FRAME_BITS'(1) : total_frames_ff;
      k_eff = (frame_index_ff > n_eff) ? n_eff : frame_index_ff;
      num   = fade_dir_ff ? (n_eff - k_eff) : k_eff;
      raw     = req_ch.sample_in;
      raw_neg = raw[SAMPLE_BITS-1];
      // full-scale negative wraps to its own pattern, read as unsigned
      mag     = raw_neg ? (~raw + SAMPLE_BITS'(1)) : raw;
      if (CMP_W'(channel_count_ff) == '0) begin
         ch_eff = CMP_W'(1);
      end else if (CMP_W'(channel_count_ff) > MAX_CH) begin
         ch_eff = MAX_CH;
      end else begin
         ch_eff = CMP_W'(channel_count_ff);
      end
      frame_last = (CMP_W'(channel_index_ff) + CMP_W'(1)) >= ch_eff;
   end

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_st.done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_st.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_DONE: out_load     = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_accept = req_ch.valid && req_ch.ready;
   assign mul_start  = req_accept;
   assign div_start  = mul_st.done;
   assign csr_ch.ready = 1'b1;
   assign csr_write  = csr_ch.valid && csr_ch.ready;

   // ---------------- configuration and counters ----------------
   always_comb begin
      fade_dir_in      = fade_dir_ff;
      total_frames_in  = total_frames_ff;
      channel_count_in = channel_count_ff;
      cfg_hit          = 1'b0;
      if (csr_write) begin
         case (csr_ch.index)
            REG_FADE_DIRECTION: begin
               fade_dir_in = csr_ch.data[0];
               cfg_hit     = 1'b1;
            end
            REG_TOTAL_FRAMES: begin
               total_frames_in = csr_ch.data;
               cfg_hit         = 1'b1;
            end
            REG_CHANNEL_COUNT: begin
               channel_count_in = csr_ch.data[CHANNEL_COUNT_BITS-1:0];
               cfg_hit          = 1'b1;
            end
            default: ;
         endcase
      end

      frame_index_in   = frame_index_ff;
      channel_index_in = channel_index_ff;
      if (cfg_hit) begin
         frame_index_in   = '0;
         channel_index_in = '0;
      end else if (req_accept) begin
         if (frame_last) begin
            channel_index_in = '0;
            frame_index_in   = (frame_index_ff < n_eff) ? frame_index_ff + FRAME_BITS'(1)
                                                        : n_eff;
         end else begin
            channel_index_in = channel_index_ff + CH_BITS'(1);
         end
      end
   end

   // ---------------- output word ----------------
   always_comb begin
      neg_in        = req_accept ? raw_neg : neg_ff;
      n_in          = req_accept ? n_eff : n_ff;
      sample_out_in = out_load ? (neg_ff ? (~quotient + SAMPLE_BITS'(1)) : quotient)
                               : sample_out_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         fade_dir_ff      <= 1'b0;
         total_frames_ff  <= FRAME_BITS'(1);
         channel_count_ff <= CHANNEL_COUNT_BITS'(1);
         frame_index_ff   <= '0;
         channel_index_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         fade_dir_ff      <= fade_dir_in;
         total_frames_ff  <= total_frames_in;
         channel_count_ff <= channel_count_in;
         frame_index_ff   <= frame_index_in;
         channel_index_ff <= channel_index_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      n_ff          <= n_in;
      sample_out_ff <= sample_out_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = sample_out_ff;

   // ---------------- serial datapath ----------------
   lfg_mul #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mag     (mag),
      .num     (num),
      .product (product),
      .status  (mul_st)
   );

   lfg_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (n_ff),
      .quotient (quotient),
      .status   (div_st)
   );

   // ---------------- checks ----------------
   `LFG_ASSERT(a_mul_done_in_mul, mul_st.done |-> state_ff == ST_MUL, "multiplier done outside MUL")
   `LFG_ASSERT(a_div_done_in_div, div_st.done |-> state_ff == ST_DIV, "divider done outside DIV")
   `LFG_ASSERT(a_units_exclusive, !(mul_st.busy && div_st.busy), "multiplier and divider both busy")
   `LFG_ASSERT(a_frame_saturates, frame_index_ff <= n_eff, "frame index past frame total")
   `LFG_ASSERT(a_accept_starts, req_accept |=> state_ff == ST_MUL && mul_st.busy, "accept did not start multiply")

endmodule

`default_nettype wire
